/* hw/rtl/omt_pkg.sv */
// Shared types, operation codes and defaults for the ordered multimap table.
`default_nettype none

package omt_pkg;

    // Default sizes
    localparam int CAPACITY_DEF   = 32;
    localparam int VALUE_BITS_DEF = 64;

    // Fixed field widths
    localparam int FUNC_W  = 2;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 64;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Cell commands
    localparam int CELL_OP_W = 3;
    localparam logic [CELL_OP_W-1:0] CELL_HOLD    = 3'd0;
    localparam logic [CELL_OP_W-1:0] CELL_ADD     = 3'd1;
    localparam logic [CELL_OP_W-1:0] CELL_MARK    = 3'd2;
    localparam logic [CELL_OP_W-1:0] CELL_COMPACT = 3'd3;
    localparam logic [CELL_OP_W-1:0] CELL_ROTATE  = 3'd4;

    // Request payload
    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [KEY_W-1:0]  key;
        logic [VALUE_W-1:0]       value;
    } req_t;

    // Result payload
    typedef struct packed {
        logic [VALUE_W-1:0] result_value;
        logic               hit;
        logic               last;
        logic               status;
    } rsp_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic [CELL_OP_W-1:0]     op;
        logic signed [KEY_W-1:0]  key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/omt_cell.sv */
// One table slot: holds a key, a value and an occupied flag, trades with its neighbor.
`default_nettype none

module omt_cell #(
    parameter int VALUE_BITS = omt_pkg::VALUE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire omt_pkg::cell_ctrl_t             ctrl,
    input  wire logic [VALUE_BITS-1:0]           add_value,
    input  wire logic                            left_valid,
    input  wire logic                            nb_valid,
    input  wire logic signed [omt_pkg::KEY_W-1:0] nb_key,
    input  wire logic [VALUE_BITS-1:0]           nb_value,
    output logic                                 valid,
    output logic signed [omt_pkg::KEY_W-1:0]     key,
    output logic [VALUE_BITS-1:0]                value
);

    logic                             valid_reg;
    logic                             valid_next;
    logic signed [omt_pkg::KEY_W-1:0] key_reg;
    logic signed [omt_pkg::KEY_W-1:0] key_next;
    logic [VALUE_BITS-1:0]            value_reg;
    logic [VALUE_BITS-1:0]            value_next;

    // Slot update per broadcast command
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        unique case (ctrl.op)
            omt_pkg::CELL_HOLD:
            begin
            end
            omt_pkg::CELL_ADD:
            begin
                // first empty slot takes the new entry
                if (!valid_reg && left_valid)
                begin
                    valid_next = 1'b1;
                    key_next   = ctrl.key;
                    value_next = add_value;
                end
            end
            omt_pkg::CELL_MARK:
            begin
                if (valid_reg && (key_reg == ctrl.key))
                    valid_next = 1'b0;
            end
            omt_pkg::CELL_COMPACT:
            begin
                // empty slot pulls from the right; a slot whose left is empty hands over
                if (!valid_reg)
                begin
                    valid_next = nb_valid;
                    key_next   = nb_key;
                    value_next = nb_value;
                end
                else if (!left_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            omt_pkg::CELL_ROTATE:
            begin
                valid_next = nb_valid;
                key_next   = nb_key;
                value_next = nb_value;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign value = value_reg;

endmodule

`default_nettype wire

/* hw/rtl/ordered_multimap_table_core.sv */
// Top level of the ordered multimap table: request sequencer and row of slots.
//
// A request is taken when start is high and busy is low; each result appears for one
// cycle with strobe high and must be taken then, as the receiver cannot stall. Add and
// the unused code give their one result in the cycle after the request and never raise
// busy. Remove clears matching slots at the edge that takes the request, then closes the
// gaps by letting every empty slot pull from its right neighbor once per cycle while a
// gap remains, then gives its result from a closing check that finds no gap. Find
// rotates the whole slot row once through slot 0 and gives its results while rotating
// and from a closing flush state. The last result of remove or find shows in the first
// cycle in which busy is low again.
`default_nettype none

module ordered_multimap_table_core #(
    parameter int CAPACITY   = omt_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = omt_pkg::VALUE_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire omt_pkg::req_t  req,
    output logic                strobe,
    output omt_pkg::rsp_t       rsp
);

    localparam int CNT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAPACITY - 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_COMPACT = 2'd1;
    localparam logic [1:0] ST_FIND    = 2'd2;
    localparam logic [1:0] ST_FLUSH   = 2'd3;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic [CNT_W-1:0]                 cnt_reg;
    logic [CNT_W-1:0]                 cnt_next;
    logic signed [omt_pkg::KEY_W-1:0] key_reg;
    logic signed [omt_pkg::KEY_W-1:0] key_next;
    logic                             pend_valid_reg;
    logic                             pend_valid_next;
    logic [VALUE_BITS-1:0]            pend_value_reg;
    logic [VALUE_BITS-1:0]            pend_value_next;
    logic                             strobe_reg;
    logic                             strobe_next;
    omt_pkg::rsp_t                    rsp_reg;
    omt_pkg::rsp_t                    rsp_next;

    omt_pkg::cell_ctrl_t              ctrl;
    logic [VALUE_BITS-1:0]            add_value;

    logic [CAPACITY-1:0]              cell_valid;
    logic signed [omt_pkg::KEY_W-1:0] cell_key   [CAPACITY];
    logic [VALUE_BITS-1:0]            cell_value [CAPACITY];
    logic [CAPACITY-1:0]              gap;
    logic                             any_gap;
    logic                             full;
    logic                             head_match;

    assign add_value = req.value[VALUE_BITS-1:0];

    // Row of slots; the tail's right neighbor is slot 0, live only while rotating
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                             lv;
        logic                             nv;
        logic signed [omt_pkg::KEY_W-1:0] nk;
        logic [VALUE_BITS-1:0]            nval;

        if (i == 0)
        begin : g_head
            assign lv = 1'b1;
        end
        else
        begin : g_body
            assign lv = cell_valid[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign nv   = cell_valid[0] && (ctrl.op == omt_pkg::CELL_ROTATE);
            assign nk   = cell_key[0];
            assign nval = cell_value[0];
            assign gap[i] = 1'b0;
        end
        else
        begin : g_link
            assign nv   = cell_valid[i+1];
            assign nk   = cell_key[i+1];
            assign nval = cell_value[i+1];
            assign gap[i] = !cell_valid[i] && cell_valid[i+1];
        end

        omt_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .add_value  (add_value),
            .left_valid (lv),
            .nb_valid   (nv),
            .nb_key     (nk),
            .nb_value   (nval),
            .valid      (cell_valid[i]),
            .key        (cell_key[i]),
            .value      (cell_value[i])
        );
    end

    assign any_gap    = |gap;
    assign full       = cell_valid[CAPACITY-1];
    assign head_match = cell_valid[0] && (cell_key[0] == key_reg);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        key_next        = key_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        strobe_next     = 1'b0;
        rsp_next        = rsp_reg;
        ctrl.op         = omt_pkg::CELL_HOLD;
        ctrl.key        = req.key;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (req.func)
                        omt_pkg::FUNC_ADD:
                        begin
                            strobe_next           = 1'b1;
                            rsp_next.result_value = '0;
                            rsp_next.hit          = 1'b0;
                            rsp_next.last         = 1'b1;
                            if (full)
                            begin
                                rsp_next.status = omt_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                rsp_next.status = omt_pkg::STATUS_OK;
                                ctrl.op         = omt_pkg::CELL_ADD;
                            end
                        end
                        omt_pkg::FUNC_REMOVE:
                        begin
                            ctrl.op    = omt_pkg::CELL_MARK;
                            state_next = ST_COMPACT;
                        end
                        omt_pkg::FUNC_FIND:
                        begin
                            key_next        = req.key;
                            cnt_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_FIND;
                        end
                        omt_pkg::FUNC_NOP:
                        begin
                            strobe_next           = 1'b1;
                            rsp_next.result_value = '0;
                            rsp_next.hit          = 1'b0;
                            rsp_next.last         = 1'b1;
                            rsp_next.status       = omt_pkg::STATUS_OK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_COMPACT:
            begin
                if (any_gap)
                begin
                    ctrl.op = omt_pkg::CELL_COMPACT;
                end
                else
                begin
                    strobe_next           = 1'b1;
                    rsp_next.result_value = '0;
                    rsp_next.hit          = 1'b0;
                    rsp_next.last         = 1'b1;
                    rsp_next.status       = omt_pkg::STATUS_OK;
                    state_next            = ST_IDLE;
                end
            end
            ST_FIND:
            begin
                ctrl.op = omt_pkg::CELL_ROTATE;
                // a held match goes out once the next one shows it was not the last
                if (head_match)
                begin
                    if (pend_valid_reg)
                    begin
                        strobe_next           = 1'b1;
                        rsp_next.result_value =
                            omt_pkg::VALUE_W'(pend_value_reg);
                        rsp_next.hit          = 1'b1;
                        rsp_next.last         = 1'b0;
                        rsp_next.status       = omt_pkg::STATUS_OK;
                    end
                    pend_valid_next = 1'b1;
                    pend_value_next = cell_value[0];
                end
                if (cnt_reg == CNT_LAST)
                    state_next = ST_FLUSH;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_FLUSH:
            begin
                strobe_next     = 1'b1;
                rsp_next.last   = 1'b1;
                rsp_next.status = omt_pkg::STATUS_OK;
                if (pend_valid_reg)
                begin
                    rsp_next.result_value = omt_pkg::VALUE_W'(pend_value_reg);
                    rsp_next.hit          = 1'b1;
                end
                else
                begin
                    rsp_next.result_value = '0;
                    rsp_next.hit          = 1'b0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        pend_value_reg <= pend_value_next;
        rsp_reg        <= rsp_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign rsp    = rsp_reg;

endmodule

`default_nettype wire

/* hw/rtl/omt_checker.sv */
// Port-level checks for the ordered multimap table, bound to the top level.
`default_nettype none

module omt_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire omt_pkg::req_t req,
    input  wire logic          strobe,
    input  wire omt_pkg::rsp_t rsp
);

    // A hit always reports ok status
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && rsp.hit |-> rsp.status == omt_pkg::STATUS_OK)
        else $error("hit result with full status");

    // A result without a hit is a single closing result carrying zero
    a_miss_shape: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !rsp.hit |-> rsp.last && (rsp.result_value == '0))
        else $error("non-hit result malformed");

    // More results pending keeps the block busy
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !rsp.last |-> busy)
        else $error("block idle with results outstanding");

    // Add and unused code answer in the next cycle and leave the block free
    a_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.func == omt_pkg::FUNC_ADD || req.func == omt_pkg::FUNC_NOP)
        |=> strobe && rsp.last && !busy)
        else $error("add or unused code result missing");

    // Remove and find occupy the block after the request
    a_long_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.func == omt_pkg::FUNC_REMOVE || req.func == omt_pkg::FUNC_FIND)
        |=> busy && !strobe)
        else $error("remove or find did not start");

endmodule

bind ordered_multimap_table_core omt_checker u_omt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .strobe (strobe),
    .rsp    (rsp)
);

`default_nettype wire

/* tb/ordered_multimap_table_core_tb.sv */
// Self-checking testbench for the ordered multimap table: directed, capacity and random tests.
module ordered_multimap_table_core_tb;

    localparam int TABLE_DEPTH  = omt_pkg::CAPACITY_DEF;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
    localparam logic [omt_pkg::VALUE_W-1:0] VALUE_MASK =
        (omt_pkg::VALUE_BITS_DEF >= omt_pkg::VALUE_W) ? {omt_pkg::VALUE_W{1'b1}} :
        ((64'd1 << omt_pkg::VALUE_BITS_DEF) - 1);

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    omt_pkg::req_t req;
    logic strobe;
    omt_pkg::rsp_t rsp;

    // Shadow copy of the table contents
    logic [omt_pkg::KEY_W-1:0]   shadow_keys [TABLE_DEPTH];
    logic [omt_pkg::VALUE_W-1:0] shadow_values [TABLE_DEPTH];
    int                          shadow_count;

    // Results still owed by the block, oldest first
    omt_pkg::rsp_t pending_results[$];
    int            mismatch_count;
    int            burst_left;

    logic [omt_pkg::KEY_W-1:0] key_pool [6];

    ordered_multimap_table_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .strobe (strobe),
        .rsp    (rsp)
    );

    always #1 clk = ~clk;

    // Append one expected result at the tail of the queue
    task automatic queue_result(input omt_pkg::rsp_t r);
        pending_results = {pending_results, r};
    endtask

    // Apply one accepted request to the shadow table and queue its results
    task automatic table_apply(input omt_pkg::req_t r);
        omt_pkg::rsp_t             res;
        int                        wr;
        int                        last_match;
        logic [omt_pkg::KEY_W-1:0] k;
        k = r.key;
        res = '0;
        res.last = 1'b1;
        res.status = omt_pkg::STATUS_OK;
        case (r.func)
            omt_pkg::FUNC_ADD:
            begin
                if (shadow_count >= TABLE_DEPTH)
                begin
                    res.status = omt_pkg::STATUS_FULL;
                end
                else
                begin
                    shadow_keys[shadow_count] = k;
                    shadow_values[shadow_count] = r.value & VALUE_MASK;
                    shadow_count++;
                end
                queue_result(res);
            end
            omt_pkg::FUNC_REMOVE:
            begin
                wr = 0;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_keys[i] != k)
                    begin
                        shadow_keys[wr] = shadow_keys[i];
                        shadow_values[wr] = shadow_values[i];
                        wr++;
                    end
                end
                shadow_count = wr;
                queue_result(res);
            end
            omt_pkg::FUNC_FIND:
            begin
                last_match = -1;
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_keys[i] == k)
                        last_match = i;
                if (last_match < 0)
                begin
                    queue_result(res);
                end
                else
                begin
                    for (int i = 0; i <= last_match; i++)
                    begin
                        if (shadow_keys[i] == k)
                        begin
                            res = '0;
                            res.result_value = shadow_values[i];
                            res.hit = 1'b1;
                            res.last = (i == last_match);
                            res.status = omt_pkg::STATUS_OK;
                            queue_result(res);
                        end
                    end
                end
            end
            default:
            begin
                // unused code: table untouched, one empty result
                queue_result(res);
            end
        endcase
    endtask

    // Sender pacing: bursts of random length, random gaps, some long unbroken runs
    task automatic pace_sender();
        int gap;
        gap = 0;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                burst_left = 40;
            end
            else
            begin
                burst_left = $urandom_range(1, 10);
                gap = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 36)
                                                  : $urandom_range(0, 8);
            end
            if (gap > 0)
            begin
                @(negedge clk);
                start = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Drive one request and hold it until the block takes it
    task automatic send_request(input logic [omt_pkg::FUNC_W-1:0] func,
                                input logic [omt_pkg::KEY_W-1:0] key,
                                input logic [omt_pkg::VALUE_W-1:0] value);
        @(negedge clk);
        start = 1'b1;
        req.func = func;
        req.key = key;
        req.value = value;
        do
            @(posedge clk);
        while (busy);
        table_apply(req);
        pace_sender();
    endtask

    function automatic logic [omt_pkg::VALUE_W-1:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        omt_pkg::rsp_t want;
        if (rst_n && strobe)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: result_value %h hit %b last %b status %b",
                       rsp.result_value, rsp.hit, rsp.last, rsp.status);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.result_value !== want.result_value)
                begin
                    $error("result_value: expected %h, got %h", want.result_value,
                           rsp.result_value);
                    mismatch_count++;
                end
                if (rsp.hit !== want.hit)
                begin
                    $error("hit: expected %b, got %b", want.hit, rsp.hit);
                    mismatch_count++;
                end
                if (rsp.last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, rsp.last);
                    mismatch_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %b, got %b", want.status, rsp.status);
                    mismatch_count++;
                end
            end
        end
    end

    // Edge keys, duplicates, misses, compaction and the unused code
    task automatic test_directed();
        send_request(omt_pkg::FUNC_FIND, 32'h0000_0000, 64'h0);
        send_request(omt_pkg::FUNC_REMOVE, 32'h0000_0005, 64'h0);
        send_request(omt_pkg::FUNC_NOP, 32'hFFFF_FFFF, {omt_pkg::VALUE_W{1'b1}});
        send_request(omt_pkg::FUNC_ADD, 32'h8000_0000, 64'h0);
        send_request(omt_pkg::FUNC_ADD, 32'h7FFF_FFFF, {omt_pkg::VALUE_W{1'b1}});
        send_request(omt_pkg::FUNC_ADD, 32'h0000_0000, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(omt_pkg::FUNC_ADD, 32'hFFFF_FFFF, 64'h5555_5555_5555_5555);
        send_request(omt_pkg::FUNC_ADD, 32'h8000_0000, 64'h1);
        send_request(omt_pkg::FUNC_ADD, 32'h7FFF_FFFF, 64'h8000_0000_0000_0000);
        send_request(omt_pkg::FUNC_ADD, 32'h8000_0000, 64'h2);
        send_request(omt_pkg::FUNC_FIND, 32'h8000_0000, rand_value());
        send_request(omt_pkg::FUNC_FIND, 32'h7FFF_FFFF, rand_value());
        send_request(omt_pkg::FUNC_FIND, 32'hFFFF_FFFF, rand_value());
        send_request(omt_pkg::FUNC_FIND, 32'h0000_0001, rand_value());
        // remove entries spread through the table, rest must keep order
        send_request(omt_pkg::FUNC_REMOVE, 32'h8000_0000, rand_value());
        send_request(omt_pkg::FUNC_FIND, 32'h8000_0000, rand_value());
        send_request(omt_pkg::FUNC_FIND, 32'h7FFF_FFFF, rand_value());
        send_request(omt_pkg::FUNC_REMOVE, 32'h0000_3039, rand_value());
        send_request(omt_pkg::FUNC_NOP, 32'h0000_0000, 64'h0);
        send_request(omt_pkg::FUNC_FIND, 32'h0000_0000, rand_value());
        send_request(omt_pkg::FUNC_REMOVE, 32'h7FFF_FFFF, rand_value());
        send_request(omt_pkg::FUNC_REMOVE, 32'h0000_0000, rand_value());
        send_request(omt_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, rand_value());
        send_request(omt_pkg::FUNC_FIND, 32'hFFFF_FFFF, rand_value());
    endtask

    // Full table, refused add, find with every slot matching, large compaction
    task automatic test_capacity();
        logic [omt_pkg::KEY_W-1:0] key_a;
        logic [omt_pkg::KEY_W-1:0] key_b;
        key_a = 32'h0F0F_0F0F;
        key_b = 32'hF0F0_F0F0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_request(omt_pkg::FUNC_ADD, key_a, rand_value());
        send_request(omt_pkg::FUNC_ADD, key_a, rand_value());
        send_request(omt_pkg::FUNC_FIND, key_a, rand_value());
        send_request(omt_pkg::FUNC_REMOVE, key_a, rand_value());
        for (int i = 0; i < 12; i++)
            send_request(omt_pkg::FUNC_ADD, (i % 2) ? key_b : key_a, rand_value());
        send_request(omt_pkg::FUNC_REMOVE, key_b, rand_value());
        send_request(omt_pkg::FUNC_FIND, key_a, rand_value());
        send_request(omt_pkg::FUNC_REMOVE, key_a, rand_value());
    endtask

    // Random mix over a small key pool so finds and removes mostly hit
    task automatic test_random(input int num_items, input int add_weight);
        int                         pick;
        int                         find_weight;
        logic [omt_pkg::FUNC_W-1:0] func;
        logic [omt_pkg::KEY_W-1:0]  key;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        for (int i = 2; i < 6; i++)
            key_pool[i] = $urandom;
        find_weight = (100 - add_weight - 4) * 2 / 3;
        for (int n = 0; n < num_items; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < add_weight)
                func = omt_pkg::FUNC_ADD;
            else if (pick < add_weight + find_weight)
                func = omt_pkg::FUNC_FIND;
            else if (pick < 96)
                func = omt_pkg::FUNC_REMOVE;
            else
                func = omt_pkg::FUNC_NOP;
            key = ($urandom_range(0, 4) == 0) ? $urandom : key_pool[$urandom_range(0, 5)];
            send_request(func, key, rand_value());
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        shadow_count = 0;
        mismatch_count = 0;
        burst_left = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_capacity();
        test_random(85, 45);
        test_random(85, 70);
        test_random(85, 30);
        test_random(85, 55);

        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
